FILE: rtl/mdte_pkg.sv
// Shared types and date arithmetic helpers for the minute date to epoch unit.
// No dependencies; imported by every module of the block.
package mdte_pkg;

    localparam int unsigned YearW   = 16;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned HourW   = 5;
    localparam int unsigned MinuteW = 6;
    localparam int unsigned TickW   = 32;
    localparam int unsigned EpochW  = 32;
    localparam int unsigned YoffW   = 7;   // year offset from 2000, 0..100
    localparam int unsigned DaysW   = 16;  // days since 1970 up to early 2100
    localparam int unsigned SecW    = 6;   // interpolated seconds, 0..59

    localparam logic [YoffW-1:0]  YoffCentury  = 7'd100;
    localparam logic [MonthW-1:0] MonthsInYear = 4'd12;
    localparam logic [MonthW-1:0] MonthMarch   = 4'd2;
    localparam logic [TickW-1:0]  MinuteMs     = 32'd60000;
    localparam logic [SecW-1:0]   SecMax       = 6'd59;
    localparam logic [15:0]       DaysTo2000   = 16'd10957;

    // One sample as held in the input register
    typedef struct packed {
        logic [YearW-1:0]   year_code;
        logic [YoffW-1:0]   year_mod;    // year_code mod 100
        logic [MonthW-1:0]  month_index;
        logic [DayW-1:0]    day_index;
        logic [HourW-1:0]   hour_value;
        logic [MinuteW-1:0] minute_value;
        logic [TickW-1:0]   tick_ms;
    } sample_t;

    // year mod 100 through a reciprocal multiply: floor(y * 83887 / 2^23)
    // is exact for every 16-bit y
    function automatic logic [YoffW-1:0] year_mod100(input logic [YearW-1:0] y);
        logic [32:0] prod;
        logic [9:0]  quot;
        logic [15:0] rem;
        prod = {17'd0, y} * 33'd83887;
        quot = prod[32:23];
        rem  = y - ({6'd0, quot} * 16'd100);
        return rem[YoffW-1:0];
    endfunction

    // Days from 1970-01-01 to January 1 of year 2000 + yo, yo in 0..100
    function automatic logic [DaysW-1:0] year_start_days(input logic [YoffW-1:0] yo);
        logic [15:0] y16;
        logic [15:0] leaps;
        y16   = {9'd0, yo};
        leaps = (y16 + 16'd3) >> 2;
        return DaysTo2000 + (y16 * 16'd365) + leaps;
    endfunction

    // Days from January 1 to the first of month m (zero-based), common year
    function automatic logic [8:0] month_start_days(input logic [MonthW-1:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Whole seconds of a millisecond span, clamped to 59. Below one minute
    // floor(e * 67109 / 2^26) equals e / 1000.
    function automatic logic [SecW-1:0] ms_to_sec_sat(input logic [TickW-1:0] e);
        logic [32:0] prod;
        prod = {17'd0, e[15:0]} * 33'd67109;
        if (e >= MinuteMs) begin
            return SecMax;
        end
        return prod[31:26];
    endfunction

endpackage

FILE: rtl/minute_date_to_epoch_interpolator_unit.sv
// Top level of the minute date to epoch interpolator.
// Depends on mdte_pkg, mdte_input_stage and mdte_epoch_core.
//
// Converts a sampled civil date and time (year code, zero-based month and
// day, hour, minute) plus a free-running millisecond tick into Unix epoch
// seconds. The year is read as 2000 + (year_code mod 100); months 12..15
// roll into the following year, and day, hour and minute add linearly, so
// out-of-range fields never fault. A year code of zero means "not synced":
// the result has time_valid low, epoch_seconds zero, and the stored anchor
// is left alone. Any other sample whose date or time fields differ from the
// last stored ones takes its own tick as the new anchor; the result is the
// start of the minute plus the whole seconds elapsed since that anchor
// (tick difference modulo 2^32), clamped to 59. Each transfer yields
// exactly one result, in order. A sample passes through the input
// register, where the year code is reduced mod 100, and then through the
// date arithmetic and anchor update into the result register. Throughput
// is one sample per cycle while out_ready is high; the anchor update
// completes in the same cycle that a sample leaves the input register,
// so consecutive samples see each other's anchor with no gap.
// in_ready follows out_ready combinationally through the two stages.
// After reset the anchor tick is zero and the stored fields hold values no
// legal sample repeats, so the first synced sample always sets the anchor.
module minute_date_to_epoch_interpolator_unit
    import mdte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [YearW-1:0]   year_code,
    input  logic [MonthW-1:0]  month_index,
    input  logic [DayW-1:0]    day_index,
    input  logic [HourW-1:0]   hour_value,
    input  logic [MinuteW-1:0] minute_value,
    input  logic [TickW-1:0]   tick_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               time_valid,
    output logic [EpochW-1:0]  epoch_seconds
);

    logic    s1_valid;
    logic    s1_take;
    sample_t s1_sample;

    // input register: accept a transfer whenever the stage is empty or drains
    mdte_input_stage u_input_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .year_code    (year_code),
        .month_index  (month_index),
        .day_index    (day_index),
        .hour_value   (hour_value),
        .minute_value (minute_value),
        .tick_ms      (tick_ms),
        .s1_valid     (s1_valid),
        .s1_take      (s1_take),
        .s1_sample    (s1_sample)
    );

    // anchor tracking, epoch arithmetic and the result register
    mdte_epoch_core u_epoch_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1_take       (s1_take),
        .s1_sample     (s1_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .time_valid    (time_valid),
        .epoch_seconds (epoch_seconds)
    );

endmodule

FILE: rtl/mdte_input_stage.sv
// Input register of the minute date to epoch unit; reduces the year code mod 100.
// Depends on mdte_pkg.
module mdte_input_stage
    import mdte_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [YearW-1:0]    year_code,
    input  logic [MonthW-1:0]   month_index,
    input  logic [DayW-1:0]     day_index,
    input  logic [HourW-1:0]    hour_value,
    input  logic [MinuteW-1:0]  minute_value,
    input  logic [TickW-1:0]    tick_ms,
    output logic                s1_valid,
    input  logic                s1_take,
    output sample_t             s1_sample
);

    logic    valid_reg;
    logic    valid_next;
    sample_t sample_reg;
    sample_t sample_next;
    logic    load;

    assign in_ready = !valid_reg || s1_take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (s1_take) begin
            valid_next = 1'b0;
        end
        sample_next.year_code    = year_code;
        sample_next.year_mod     = year_mod100(year_code);
        sample_next.month_index  = month_index;
        sample_next.day_index    = day_index;
        sample_next.hour_value   = hour_value;
        sample_next.minute_value = minute_value;
        sample_next.tick_ms      = tick_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // hold payload until the next transfer
    always_ff @(posedge clk)
    begin
        if (load) begin
            sample_reg <= sample_next;
        end
    end

    assign s1_valid  = valid_reg;
    assign s1_sample = sample_reg;

endmodule

FILE: rtl/mdte_epoch_core.sv
// Anchor state, epoch arithmetic and result register of the minute date unit.
// Depends on mdte_pkg.
module mdte_epoch_core
    import mdte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s1_valid,
    output logic               s1_take,
    input  sample_t            s1_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               time_valid,
    output logic [EpochW-1:0]  epoch_seconds
);

    logic [YearW-1:0]   seen_year_reg,   seen_year_next;
    logic [MonthW-1:0]  seen_month_reg,  seen_month_next;
    logic [DayW-1:0]    seen_day_reg,    seen_day_next;
    logic [HourW-1:0]   seen_hour_reg,   seen_hour_next;
    logic [MinuteW-1:0] seen_minute_reg, seen_minute_next;
    logic [TickW-1:0]   anchor_reg,      anchor_next;
    logic               out_valid_reg,   out_valid_next;
    logic               tv_reg,          tv_next;
    logic [EpochW-1:0]  epoch_reg,       epoch_next;

    logic               fire;
    logic               synced;
    logic               changed;
    logic [TickW-1:0]   anchor_eff;
    logic [TickW-1:0]   elapsed_ms;
    logic [SecW-1:0]    elapsed_s;
    logic               month_wrap;
    logic [YoffW-1:0]   yoff;
    logic [MonthW-1:0]  month_eff;
    logic               leap;
    logic [DaysW-1:0]   days;
    logic [32:0]        day_secs;
    logic [EpochW-1:0]  tod_secs;

    assign s1_take = !out_valid_reg || out_ready;
    assign fire    = s1_valid && s1_take;
    assign synced  = (s1_sample.year_code != '0);

    assign changed = (s1_sample.year_code    != seen_year_reg)
                  || (s1_sample.month_index  != seen_month_reg)
                  || (s1_sample.day_index    != seen_day_reg)
                  || (s1_sample.hour_value   != seen_hour_reg)
                  || (s1_sample.minute_value != seen_minute_reg);

    always_comb
    begin
        // a changed sample anchors at its own tick
        anchor_eff = changed ? s1_sample.tick_ms : anchor_reg;
        elapsed_ms = s1_sample.tick_ms - anchor_eff;
        elapsed_s  = ms_to_sec_sat(elapsed_ms);

        // months 12..15 roll into the next year
        month_wrap = (s1_sample.month_index >= MonthsInYear);
        yoff       = s1_sample.year_mod + {6'd0, month_wrap};
        month_eff  = month_wrap ? (s1_sample.month_index - MonthsInYear)
                                : s1_sample.month_index;
        leap       = (yoff[1:0] == 2'b00) && (yoff != YoffCentury);

        days = year_start_days(yoff)
             + {7'd0, month_start_days(month_eff)}
             + {15'd0, (leap && (month_eff >= MonthMarch))}
             + {11'd0, s1_sample.day_index};

        day_secs = {17'd0, days} * 33'd86400;
        tod_secs = ({27'd0, s1_sample.hour_value} * 32'd3600)
                 + ({26'd0, s1_sample.minute_value} * 32'd60)
                 + {26'd0, elapsed_s};

        seen_year_next   = seen_year_reg;
        seen_month_next  = seen_month_reg;
        seen_day_next    = seen_day_reg;
        seen_hour_next   = seen_hour_reg;
        seen_minute_next = seen_minute_reg;
        anchor_next      = anchor_reg;
        if (fire && synced && changed) begin
            seen_year_next   = s1_sample.year_code;
            seen_month_next  = s1_sample.month_index;
            seen_day_next    = s1_sample.day_index;
            seen_hour_next   = s1_sample.hour_value;
            seen_minute_next = s1_sample.minute_value;
            anchor_next      = s1_sample.tick_ms;
        end

        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end

        tv_next    = synced;
        epoch_next = synced ? (day_secs[EpochW-1:0] + tod_secs) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seen_year_reg   <= '0;
            seen_month_reg  <= '1;
            seen_day_reg    <= '1;
            seen_hour_reg   <= '1;
            seen_minute_reg <= '1;
            anchor_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            seen_year_reg   <= seen_year_next;
            seen_month_reg  <= seen_month_next;
            seen_day_reg    <= seen_day_next;
            seen_hour_reg   <= seen_hour_next;
            seen_minute_reg <= seen_minute_next;
            anchor_reg      <= anchor_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // hold result payload while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (fire) begin
            tv_reg    <= tv_next;
            epoch_reg <= epoch_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign time_valid    = tv_reg;
    assign epoch_seconds = epoch_reg;

endmodule

FILE: rtl/mdte_checker.sv
// Port-level checks for the minute date to epoch interpolator.
// Depends on mdte_pkg; bound to minute_date_to_epoch_interpolator_unit.
module mdte_checker
    import mdte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               time_valid,
    input  logic [EpochW-1:0]  epoch_seconds
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(epoch_seconds)
                                    && $stable(time_valid))
        else $error("result changed while stalled");

    // unsynced results carry epoch zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !time_valid |-> epoch_seconds == '0)
        else $error("invalid result with nonzero epoch");

    // synced results start at 2000-01-01; the top end is the latest roll-over
    // of out-of-range fields (April 2100, day 31, hour 31, minute 63, 59 s)
    a_epoch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && time_valid |-> epoch_seconds >= 32'd946684800
                                    && epoch_seconds <= 32'd4113014639)
        else $error("epoch out of range");

    // an input transfer is followed by out_valid, checked after the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("result missing after transfer");

endmodule

bind minute_date_to_epoch_interpolator_unit mdte_checker u_mdte_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .time_valid    (time_valid),
    .epoch_seconds (epoch_seconds)
);
